[sv/htb_pkg.sv]
// ----------------------------------------------------------------------------
// Huffman tree builder package
// Shared widths, defaults, command and status codes, and the node id mapping.
// ----------------------------------------------------------------------------
package htb_pkg;

    // Defaults for the top level parameters.
    localparam int SYMBOLS_DEF    = 256;
    localparam int ROOT_BASE_DEF  = 300;
    localparam int COUNT_BITS_DEF = 24;

    // Node store geometry: entries below INNER_BASE are symbols, the rest
    // hold internal nodes in order of creation.
    localparam int STORE_DEPTH = 512;
    localparam int INNER_BASE  = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths of the channels.
    localparam int CMD_W    = 2;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 10;
    localparam int FREQ_W   = 24;
    localparam int MERGE_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_COUNT = 2'd0,
        CMD_MERGE = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MERGED   = 2'd0,
        ST_FINISHED = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    // Maps a store entry to its external node id.
    function automatic logic [ID_W-1:0] node_id(logic [ADDR_W-1:0] entry, int root_base);
        logic [ID_W-1:0] id;
        if (entry[ADDR_W-1])
        begin
            id = ID_W'(root_base + int'(entry[ADDR_W-2:0]));
        end
        else
        begin
            id = ID_W'(entry[ADDR_W-2:0]);
        end
        return id;
    endfunction

endpackage

[sv/htb_in_if.sv]
// ----------------------------------------------------------------------------
// Huffman tree builder command channel
// Valid/ready channel that carries one command beat: cmd and symbol.
// ----------------------------------------------------------------------------
interface htb_in_if;
    logic                      valid;
    logic                      ready;
    logic [htb_pkg::CMD_W-1:0] cmd;
    logic [htb_pkg::SYM_W-1:0] symbol;

    modport source (output valid, output cmd, output symbol, input ready);
    modport sink   (input valid, input cmd, input symbol, output ready);
endinterface

[sv/htb_out_if.sv]
// ----------------------------------------------------------------------------
// Huffman tree builder result channel
// Valid/ready channel that carries one merge result beat.
// ----------------------------------------------------------------------------
interface htb_out_if;
    logic                         valid;
    logic                         ready;
    logic [htb_pkg::STATUS_W-1:0] status;
    logic [htb_pkg::ID_W-1:0]     parent_id;
    logic [htb_pkg::ID_W-1:0]     zero_child;
    logic [htb_pkg::ID_W-1:0]     one_child;
    logic [htb_pkg::FREQ_W-1:0]   parent_freq;

    modport source (output valid, output status, output parent_id, output zero_child,
                    output one_child, output parent_freq, input ready);
    modport sink   (input valid, input status, input parent_id, input zero_child,
                    input one_child, input parent_freq, output ready);
endinterface

[sv/huffman_tree_builder_top.sv]
// ----------------------------------------------------------------------------
// Huffman tree builder
// Counts byte symbols and builds the Huffman tree one merge step per command.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  -------  ---------  ----------------------------------------------------
//  in_ch    sink       cmd (count / merge / clear), symbol
//  out_ch   source     status, parent_id, zero_child, one_child, parent_freq
//
// A count beat is a read, then a write of the symbol's count.
// A merge beat has one compare unit walk all 512 store entries, one per cycle
// through the single read port; when two nodes are merged, three writes on the
// single write port follow; last comes a hand-off to the output register.
// A clear beat, and the period right after reset, is a clearing pass that
// writes every store entry to zero; in_ch.ready stays low then.
// The output register holds a finished result until it is taken; the next
// command is accepted while it waits, and a later result stalls only if the
// earlier one has still not been taken.
//
module huffman_tree_builder_top #(
    parameter int SYMBOLS    = htb_pkg::SYMBOLS_DEF,
    parameter int ROOT_BASE  = htb_pkg::ROOT_BASE_DEF,
    parameter int COUNT_BITS = htb_pkg::COUNT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    htb_in_if.sink    in_ch,
    htb_out_if.source out_ch
);

    localparam int ADDR_W = htb_pkg::ADDR_W;
    localparam int ID_W   = htb_pkg::ID_W;
    localparam int FREQ_W = htb_pkg::FREQ_W;
    localparam int SYM_W  = htb_pkg::SYM_W;
    localparam int WORD_W = COUNT_BITS + 1;
    localparam int EXT_W  = COUNT_BITS + FREQ_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Each store word is {live, count}.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT_WR,
        S_SCAN,
        S_LAST,
        S_DECIDE,
        S_RET1,
        S_RET2,
        S_NEW,
        S_OUT
    } state_t;

    // Results are reported as the low FREQ_W bits of a count.
    function automatic logic [FREQ_W-1:0] to_freq(logic [COUNT_BITS-1:0] c);
        logic [EXT_W-1:0] e;
        e = EXT_W'(c);
        return e[FREQ_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Node store: one write port, one registered read port.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] store_mem [htb_pkg::STORE_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Sequencer state and registers
    // ------------------------------------------------------------------
    state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]           scan_idx_reg, scan_idx_next;
    logic                        chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0]           chk_idx_reg, chk_idx_next;
    logic [SYM_W-1:0]            sym_reg, sym_next;
    logic [htb_pkg::MERGE_W-1:0] merges_reg, merges_next;

    // The two best candidates found so far in the current scan.
    logic                  b1_vld_reg, b1_vld_next;
    logic [ADDR_W-1:0]     b1_idx_reg, b1_idx_next;
    logic [COUNT_BITS-1:0] b1_cnt_reg, b1_cnt_next;
    logic                  b2_vld_reg, b2_vld_next;
    logic [ADDR_W-1:0]     b2_idx_reg, b2_idx_next;
    logic [COUNT_BITS-1:0] b2_cnt_reg, b2_cnt_next;
    logic [COUNT_BITS-1:0] sum_reg, sum_next;

    // Finished result waiting for the output register.
    htb_pkg::status_t  res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_parent_reg, res_parent_next;
    logic [ID_W-1:0]   res_zero_reg, res_zero_next;
    logic [ID_W-1:0]   res_one_reg, res_one_next;
    logic [FREQ_W-1:0] res_freq_reg, res_freq_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    htb_pkg::status_t  out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_parent_reg, out_parent_next;
    logic [ID_W-1:0]   out_zero_reg, out_zero_next;
    logic [ID_W-1:0]   out_one_reg, out_one_next;
    logic [FREQ_W-1:0] out_freq_reg, out_freq_next;

    // Shared compare unit and helpers.
    logic                  rd_live;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  cand_lt_b1;
    logic                  cand_lt_b2;
    logic [COUNT_BITS:0]   sum_wide;
    logic [COUNT_BITS-1:0] sum_sat;
    logic [ADDR_W-1:0]     slot;
    logic                  sym_ok;
    logic                  in_fire;

    assign rd_live    = rd_data_reg[COUNT_BITS];
    assign rd_cnt     = rd_data_reg[COUNT_BITS-1:0];
    assign cand_lt_b1 = !b1_vld_reg || (rd_cnt < b1_cnt_reg);
    assign cand_lt_b2 = !b2_vld_reg || (rd_cnt < b2_cnt_reg);
    assign sum_wide   = {1'b0, b1_cnt_reg} + {1'b0, b2_cnt_reg};
    assign sum_sat    = sum_wide[COUNT_BITS] ? COUNT_MAX : sum_wide[COUNT_BITS-1:0];
    assign slot       = ADDR_W'(htb_pkg::INNER_BASE) + ADDR_W'(merges_reg);
    assign sym_ok     = ({1'b0, in_ch.symbol} < (SYM_W+1)'(SYMBOLS));

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        sym_next        = sym_reg;
        merges_next     = merges_reg;
        b1_vld_next     = b1_vld_reg;
        b1_idx_next     = b1_idx_reg;
        b1_cnt_next     = b1_cnt_reg;
        b2_vld_next     = b2_vld_reg;
        b2_idx_next     = b2_idx_reg;
        b2_cnt_next     = b2_cnt_reg;
        sum_next        = sum_reg;
        res_status_next = res_status_reg;
        res_parent_next = res_parent_reg;
        res_zero_next   = res_zero_reg;
        res_one_next    = res_one_reg;
        res_freq_next   = res_freq_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_parent_next = out_parent_reg;
        out_zero_next   = out_zero_reg;
        out_one_next    = out_one_reg;
        out_freq_next   = out_freq_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_idx_reg;
        mem_wdata       = '0;
        rd_addr         = scan_idx_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Running two-minimum search; an equal count never displaces the
        // earlier, lower entry, so ties go to the lower node id.
        if (chk_vld_reg && rd_live)
        begin
            if (cand_lt_b1)
            begin
                b2_vld_next = b1_vld_reg;
                b2_idx_next = b1_idx_reg;
                b2_cnt_next = b1_cnt_reg;
                b1_vld_next = 1'b1;
                b1_idx_next = chk_idx_reg;
                b1_cnt_next = rd_cnt;
            end
            else if (cand_lt_b2)
            begin
                b2_vld_next = 1'b1;
                b2_idx_next = chk_idx_reg;
                b2_cnt_next = rd_cnt;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = scan_idx_reg;
                mem_wdata     = '0;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (htb_pkg::cmd_t'(in_ch.cmd))
                        htb_pkg::CMD_COUNT:
                        begin
                            // Counting stops once the tree has started.
                            if (sym_ok && (merges_reg == '0))
                            begin
                                sym_next   = in_ch.symbol;
                                rd_addr    = ADDR_W'(in_ch.symbol);
                                state_next = S_CNT_WR;
                            end
                        end
                        htb_pkg::CMD_MERGE:
                        begin
                            scan_idx_next = '0;
                            b1_vld_next   = 1'b0;
                            b2_vld_next   = 1'b0;
                            state_next    = S_SCAN;
                        end
                        htb_pkg::CMD_CLEAR:
                        begin
                            merges_next   = '0;
                            scan_idx_next = '0;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CNT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(sym_reg);
                mem_wdata  = {1'b1, (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1};
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                rd_addr       = scan_idx_reg;
                chk_vld_next  = 1'b1;
                chk_idx_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == '1)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                res_zero_next = '0;
                res_one_next  = '0;
                if (!b1_vld_reg)
                begin
                    res_status_next = htb_pkg::ST_EMPTY;
                    res_parent_next = '0;
                    res_freq_next   = '0;
                    state_next      = S_OUT;
                end
                else if (!b2_vld_reg)
                begin
                    res_status_next = htb_pkg::ST_FINISHED;
                    res_parent_next = htb_pkg::node_id(b1_idx_reg, ROOT_BASE);
                    res_freq_next   = to_freq(b1_cnt_reg);
                    state_next      = S_OUT;
                end
                else
                begin
                    res_status_next = htb_pkg::ST_MERGED;
                    res_parent_next = htb_pkg::node_id(slot, ROOT_BASE);
                    res_zero_next   = htb_pkg::node_id(b2_idx_reg, ROOT_BASE);
                    res_one_next    = htb_pkg::node_id(b1_idx_reg, ROOT_BASE);
                    res_freq_next   = to_freq(sum_sat);
                    sum_next        = sum_sat;
                    state_next      = S_RET1;
                end
            end
            S_RET1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = b1_idx_reg;
                mem_wdata  = {1'b0, b1_cnt_reg};
                state_next = S_RET2;
            end
            S_RET2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = b2_idx_reg;
                mem_wdata  = {1'b0, b2_cnt_reg};
                state_next = S_NEW;
            end
            S_NEW:
            begin
                mem_we      = 1'b1;
                mem_waddr   = slot;
                mem_wdata   = {1'b1, sum_reg};
                merges_next = merges_reg + 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_parent_next = res_parent_reg;
                    out_zero_next   = res_zero_reg;
                    out_one_next    = res_one_reg;
                    out_freq_next   = res_freq_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            scan_idx_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            sym_reg        <= '0;
            merges_reg     <= '0;
            b1_vld_reg     <= 1'b0;
            b1_idx_reg     <= '0;
            b1_cnt_reg     <= '0;
            b2_vld_reg     <= 1'b0;
            b2_idx_reg     <= '0;
            b2_cnt_reg     <= '0;
            sum_reg        <= '0;
            res_status_reg <= htb_pkg::ST_EMPTY;
            res_parent_reg <= '0;
            res_zero_reg   <= '0;
            res_one_reg    <= '0;
            res_freq_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= htb_pkg::ST_EMPTY;
            out_parent_reg <= '0;
            out_zero_reg   <= '0;
            out_one_reg    <= '0;
            out_freq_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            chk_vld_reg    <= chk_vld_next;
            chk_idx_reg    <= chk_idx_next;
            sym_reg        <= sym_next;
            merges_reg     <= merges_next;
            b1_vld_reg     <= b1_vld_next;
            b1_idx_reg     <= b1_idx_next;
            b1_cnt_reg     <= b1_cnt_next;
            b2_vld_reg     <= b2_vld_next;
            b2_idx_reg     <= b2_idx_next;
            b2_cnt_reg     <= b2_cnt_next;
            sum_reg        <= sum_next;
            res_status_reg <= res_status_next;
            res_parent_reg <= res_parent_next;
            res_zero_reg   <= res_zero_next;
            res_one_reg    <= res_one_next;
            res_freq_reg   <= res_freq_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_parent_reg <= out_parent_next;
            out_zero_reg   <= out_zero_next;
            out_one_reg    <= out_one_next;
            out_freq_reg   <= out_freq_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.parent_id   = out_parent_reg;
    assign out_ch.zero_child  = out_zero_reg;
    assign out_ch.one_child   = out_one_reg;
    assign out_ch.parent_freq = out_freq_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The second candidate never exists without the first, and is a
    // different store entry.
    a_two_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        b2_vld_reg |-> (b1_vld_reg && (b1_idx_reg != b2_idx_reg)))
        else $error("second minimum without a distinct first minimum");

    // The first candidate never has a larger count than the second.
    a_min_order: assert property (@(posedge clk) disable iff (!rst_n)
        (b1_vld_reg && b2_vld_reg) |-> (b1_cnt_reg <= b2_cnt_reg))
        else $error("minimum candidates out of order");

    // The merge counter only moves when a new node is written or on clear.
    a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
        (merges_reg != $past(merges_reg)) |->
            ($past(state_reg == S_NEW) || (merges_reg == '0)))
        else $error("merge counter changed outside a node write");

    // A result beat only appears after the hand-off step.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside the hand-off step");

endmodule
